/* rtl/tpd_pkg.sv */
package tpd_pkg;

    // Packet framing
    localparam logic [2:0] POS_START = 3'd0;
    localparam logic [2:0] POS_LAST  = 3'd6;
    localparam int         MARK_BIT  = 7;
    localparam int         SYNC_BIT  = 4;

    // Scaling: x = rawB * 1200 / 8192, y = 825 - rawA * 825 / 6144 = 825 - rawA * 275 / 2048
    localparam int X_PROD_W = 27;
    localparam int Y_PROD_W = 25;
    localparam logic [X_PROD_W-1:0] X_SCALE = X_PROD_W'(1200);
    localparam logic [Y_PROD_W-1:0] Y_SCALE = Y_PROD_W'(275);
    localparam int X_SHIFT = 13;
    localparam int Y_SHIFT = 11;
    localparam logic [14:0] Y_OFFSET = 15'd825;

    // Decoupling queue between the front and back parts
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // One unpacked packet waiting for scaling
    typedef struct packed {
        logic [15:0] raw_a;
        logic [15:0] raw_b;
        logic [9:0]  press;
    } pkt_t;

endpackage

/* rtl/tpd_front.sv */
module tpd_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_accept,
    input  logic [7:0]       rx_byte,
    output logic             push,
    output tpd_pkg::pkt_t    push_data
);
    import tpd_pkg::*;

    logic [2:0] pos_reg, pos_next;
    logic       bad_reg, bad_next;
    logic [7:0] byte_reg [1:5];
    logic       is_last;

    // Positions of six or more all count as the final byte.
    assign is_last = (pos_reg >= POS_LAST);

    // Position and bad-marker tracking.
    always_comb begin
        pos_next = pos_reg;
        bad_next = bad_reg;
        if (in_accept) begin
            if (pos_reg == POS_START) begin
                if (rx_byte[MARK_BIT] && !rx_byte[SYNC_BIT]) begin
                    pos_next = 3'd1;
                    bad_next = 1'b0;
                end
            end else if (is_last) begin
                pos_next = POS_START;
            end else begin
                pos_next = pos_reg + 3'd1;
                bad_next = bad_reg | rx_byte[MARK_BIT];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= POS_START;
            bad_reg <= 1'b0;
        end else begin
            pos_reg <= pos_next;
            bad_reg <= bad_next;
        end
    end

    // Byte store for positions one to five; the final byte is used live.
    always_ff @(posedge aclk) begin
        for (int i = 1; i <= 5; i++) begin
            if (in_accept && pos_reg == 3'(i)) begin
                byte_reg[i] <= rx_byte;
            end
        end
    end

    // A clean packet is unpacked and handed to the queue on its final byte.
    assign push = in_accept && is_last && !bad_reg && !rx_byte[MARK_BIT];
    assign push_data.raw_a = {byte_reg[1][6:0], byte_reg[2][6:0], rx_byte[6:5]};
    assign push_data.raw_b = {byte_reg[3][6:0], byte_reg[4][6:0], rx_byte[4:3]};
    assign push_data.press = {rx_byte[2:0], byte_reg[5][6:0]};

endmodule

/* rtl/tpd_queue.sv */
module tpd_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  tpd_pkg::pkt_t    push_data,
    input  logic             pop,
    output logic             full,
    output logic             not_empty,
    output tpd_pkg::pkt_t    pop_data
);
    import tpd_pkg::*;

    pkt_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == QCNT_W'(QDEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = mem_reg[rd_ptr_reg];

    // Occupancy follows pushes and pops.
    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + QCNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + QPTR_W'(1);
            end
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    // A push never lands on a full queue and a pop never drains an empty one.
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full) else $error("queue overflow");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> not_empty) else $error("queue underflow");
    // Occupancy stays within the depth.
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QCNT_W'(QDEPTH)) else $error("queue count out of range");

endmodule

/* rtl/tpd_back.sv */
module tpd_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_not_empty,
    input  tpd_pkg::pkt_t       q_data,
    output logic                pop,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [13:0]         m_report_x,
    output logic signed [13:0]  m_report_y,
    output logic [9:0]          m_pressure,
    output logic                m_touching
);
    import tpd_pkg::*;

    logic                valid_reg;
    logic [X_PROD_W-1:0] x_prod;
    logic [Y_PROD_W-1:0] y_prod;
    logic [13:0]         y_quot;
    logic [14:0]         y_diff;
    logic [13:0]         x_reg;
    logic [13:0]         y_reg;
    logic [9:0]          press_reg;

    // Take the next packet whenever the output register is free or being emptied.
    assign pop = q_not_empty && (!valid_reg || m_ready);

    // Constant scaling, one multiplier per coordinate.
    assign x_prod = X_PROD_W'(q_data.raw_b) * X_SCALE;
    assign y_prod = Y_PROD_W'(q_data.raw_a) * Y_SCALE;
    assign y_quot = y_prod[Y_PROD_W-1:Y_SHIFT];
    assign y_diff = Y_OFFSET - {1'b0, y_quot};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (pop) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    // Output payload register.
    always_ff @(posedge aclk) begin
        if (pop) begin
            x_reg     <= x_prod[X_PROD_W-1:X_SHIFT];
            y_reg     <= y_diff[13:0];
            press_reg <= q_data.press;
        end
    end

    assign m_valid    = valid_reg;
    assign m_report_x = x_reg;
    assign m_report_y = signed'(y_reg);
    assign m_pressure = press_reg;
    assign m_touching = (press_reg != '0);

endmodule

/* rtl/touch_packet_decoder.sv */
// Touch packet decoder: takes one serial byte per item and assembles 7-byte digitizer
// packets that open on a byte with bit 7 set and bit 4 clear; for each clean packet
// (no bit 7 in the six following bytes) it emits one report with scaled X, signed Y,
// 10-bit pressure and a touch flag. A byte is taken every cycle; s_ready drops only
// when two finished reports sit in the internal queue while the output is stalled.
// A report is written into the two-entry queue when its final byte is accepted and is
// then scaled into the output register as it leaves the queue, which raises m_valid;
// while the output is stalled the report waits in the queue.
module touch_packet_decoder (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [7:0]          s_rx_byte,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [13:0]         m_report_x,
    output logic signed [13:0]  m_report_y,
    output logic [9:0]          m_pressure,
    output logic                m_touching
);
    import tpd_pkg::*;

    logic in_accept;
    logic push, pop, q_full, q_not_empty;
    pkt_t push_data, pop_data;

    assign s_ready   = !q_full;
    assign in_accept = s_valid && s_ready;

    // Framing and unpacking.
    tpd_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (in_accept),
        .rx_byte   (s_rx_byte),
        .push      (push),
        .push_data (push_data)
    );

    // Queue between framing and scaling.
    tpd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .pop_data  (pop_data)
    );

    // Scaling and the output register.
    tpd_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .q_data      (pop_data),
        .pop         (pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_report_x  (m_report_x),
        .m_report_y  (m_report_y),
        .m_pressure  (m_pressure),
        .m_touching  (m_touching)
    );

endmodule
